// File: design/plg_pkg.sv
// ----------------------------------------------------------------------------
// plg_pkg
// Shared types, constants and command codes of the point list geometry engine.
// ----------------------------------------------------------------------------
package plg_pkg;

	localparam int MaxPointsDef = 8;
	localparam int CoordBitsDef = 16;
	localparam int LenBits = 28;
	localparam int DistBits = 33;

	typedef enum logic [2:0] {
		KIND_APPEND = 3'd0,
		KIND_INSERT = 3'd1,
		KIND_DELETE = 3'd2,
		KIND_PATH   = 3'd3,
		KIND_FAR    = 3'd4,
		KIND_BOX    = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_BADIDX = 2'd2,
		ST_FEW    = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]   kind;
		logic [3:0]   position;
		logic signed [15:0] coord_x;
		logic signed [15:0] coord_y;
	} plg_req_t;

	typedef struct packed {
		logic [1:0]   status;
		logic [3:0]   point_count;
		logic [27:0]  path_length;
		logic [2:0]   far_first;
		logic [2:0]   far_second;
		logic [32:0]  far_dist_sq;
		logic signed [15:0] box_min_x;
		logic signed [15:0] box_min_y;
		logic signed [15:0] box_max_x;
		logic signed [15:0] box_max_y;
	} plg_rsp_t;

endpackage

// File: design/point_list_geometry_engine_core.sv
// ----------------------------------------------------------------------------
// point_list_geometry_engine_core
// Ordered point list in RAM with append, insert, delete, path length,
// farthest pair and bounding box requests.
// ----------------------------------------------------------------------------
// channel | direction | signals
// req     | in        | req_valid, req_ready, req (plg_req_t)
// rsp     | out       | rsp_valid, rsp_ready, rsp (plg_rsp_t)
// One request at a time. Insert and delete move points one by one, path
// length takes a bit-serial square root per segment, farthest pair reads
// every pair from the single RAM read port, bounding box reads each point.
// Reset clears state, count and rsp_valid; RAM stays undefined until written.
// A finished response waits in the output register while rsp_ready is low.
// ----------------------------------------------------------------------------
module point_list_geometry_engine_core
	import plg_pkg::*;
#(
	parameter int MaxPoints = MaxPointsDef,
	parameter int CoordBits = CoordBitsDef
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  plg_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output plg_rsp_t rsp
);
	localparam int Ab = $clog2(MaxPoints);
	localparam int Cb = $clog2(MaxPoints + 1);
	localparam int Pw = 2 * CoordBits;
	localparam int Db = 2 * CoordBits + 1;
	localparam int Sb = Db + 16 + (Db % 2);
	localparam logic [LenBits-1:0] LenMax = '1;

	typedef enum logic [3:0] {
		S_IDLE, S_RDA, S_RDB, S_WAITA, S_GETA, S_GETB, S_MOVE, S_WRNEW,
		S_MUL, S_SUM, S_SQRT, S_NEXT, S_DONE
	} state_t;

	state_t state_q;
	plg_req_t req_q;
	logic [Cb-1:0] cnt_q;
	logic [Cb-1:0] i_q, j_q;
	logic [Pw-1:0] a_q;
	logic [Pw-1:0] b_q;
	logic [CoordBits:0] dx_q, dy_q;
	logic [Db-1:0] d_q;
	logic [Db-1:0] best_q;
	logic [Ab-1:0] b1_q, b2_q;
	logic [LenBits:0] sum_q;
	logic signed [CoordBits-1:0] mnx_q, mny_q, mxx_q, mxy_q;
	logic first_q;
	logic sq_start_q;

	logic we;
	logic [Ab-1:0] waddr, raddr;
	logic [Pw-1:0] wdata, rdata;
	logic sq_busy;
	logic [Sb/2:0] root;
	logic signed [CoordBits-1:0] rx, ry, ax, ay;
	logic signed [CoordBits:0] ddx, ddy;
	logic [Db-1:0] dsum;
	status_t acc_status;
	state_t acc_state;

	plg_ram #(.Width(Pw), .Depth(MaxPoints)) u_ram (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	plg_sqrt #(.InBits(Sb)) u_sqrt (
		.clk, .arst_n, .start(sq_start_q),
		.radicand({{(Sb-Db-16){1'b0}}, d_q, 16'h0000}),
		.busy(sq_busy), .root
	);

	assign rx = rdata[Pw-1 -: CoordBits];
	assign ry = rdata[CoordBits-1:0];
	assign ax = a_q[Pw-1 -: CoordBits];
	assign ay = a_q[CoordBits-1:0];
	assign ddx = {ax[CoordBits-1], ax} - {rx[CoordBits-1], rx};
	assign ddy = {ay[CoordBits-1], ay} - {ry[CoordBits-1], ry};
	assign dsum = Db'(dx_q * dx_q) + Db'(dy_q * dy_q);
	assign req_ready = (state_q == S_IDLE) && !rsp_valid;

	always_comb begin
		acc_status = ST_OK;
		acc_state = S_DONE;
		case (req.kind)
			KIND_APPEND, KIND_INSERT: begin
				if (cnt_q >= Cb'(MaxPoints)) begin
					acc_status = ST_FULL;
				end else if (req.kind == KIND_INSERT && Cb'(req.position) > cnt_q) begin
					acc_status = ST_BADIDX;
				end else begin
					acc_state = (req.kind == KIND_APPEND) ? S_WRNEW : S_RDA;
				end
			end
			KIND_DELETE: begin
				if (Cb'(req.position) >= cnt_q) begin
					acc_status = ST_BADIDX;
				end else begin
					acc_state = S_RDA;
				end
			end
			KIND_PATH: begin
				if (cnt_q >= Cb'(2)) begin
					acc_state = S_RDA;
				end
			end
			KIND_FAR: begin
				if (cnt_q < Cb'(2)) begin
					acc_status = ST_FEW;
				end else begin
					acc_state = S_RDA;
				end
			end
			KIND_BOX: begin
				if (cnt_q == '0) begin
					acc_status = ST_FEW;
				end else begin
					acc_state = S_RDA;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		we = 1'b0;
		waddr = i_q[Ab-1:0];
		wdata = rdata;
		raddr = i_q[Ab-1:0];
		case (state_q)
			S_IDLE, S_NEXT: raddr = i_q[Ab-1:0];
			S_RDB: raddr = (req_q.kind inside {KIND_INSERT, KIND_DELETE}) ?
				i_q[Ab-1:0] : j_q[Ab-1:0];
			S_WAITA: raddr = j_q[Ab-1:0];
			S_MOVE: begin
				we = 1'b1;
				waddr = j_q[Ab-1:0];
			end
			S_WRNEW: begin
				we = 1'b1;
				wdata = Pw'({CoordBits'(req_q.coord_x), CoordBits'(req_q.coord_y)});
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			rsp_valid <= 1'b0;
			sq_start_q <= 1'b0;
		end else begin
			sq_start_q <= (state_q == S_SUM) && (req_q.kind == KIND_PATH);
			if (rsp_valid && rsp_ready) begin
				rsp_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid && req_ready) begin
						req_q <= req;
						rsp <= '{status: acc_status, default: '0};
						sum_q <= '0;
						first_q <= 1'b1;
						state_q <= acc_state;
						case (req.kind)
							KIND_APPEND, KIND_INSERT: begin
								i_q <= cnt_q;
								j_q <= cnt_q;
							end
							KIND_DELETE: begin
								j_q <= Cb'(req.position);
								i_q <= Cb'(req.position);
							end
							KIND_PATH, KIND_BOX: begin
								i_q <= '0;
								j_q <= Cb'(1);
							end
							KIND_FAR: begin
								i_q <= '0;
								j_q <= Cb'(1);
								best_q <= '0;
								b1_q <= '0;
								b2_q <= Ab'(1);
							end
							default: ;
						endcase
					end
				end
				S_RDA: begin
					// RAM read address was set from i_q; data arrives next cycle.
					case (req_q.kind)
						KIND_INSERT: begin
							if (i_q == Cb'(req_q.position)) begin
								state_q <= S_WRNEW;
							end else begin
								i_q <= i_q - 1'b1;
								state_q <= S_RDB;
							end
						end
						KIND_DELETE: begin
							if (i_q + 1'b1 >= cnt_q) begin
								cnt_q <= cnt_q - 1'b1;
								state_q <= S_DONE;
							end else begin
								i_q <= i_q + 1'b1;
								state_q <= S_RDB;
							end
						end
						KIND_BOX: state_q <= S_GETA;
						default: state_q <= S_RDB;
					endcase
				end
				S_RDB: begin
					case (req_q.kind)
						KIND_INSERT, KIND_DELETE: state_q <= S_MOVE;
						default: begin
							a_q <= rdata;
							state_q <= S_WAITA;
						end
					endcase
				end
				S_WAITA: state_q <= S_GETB;
				S_GETB: begin
					dx_q <= ddx[CoordBits] ? (CoordBits+1)'(0) - ddx : ddx;
					dy_q <= ddy[CoordBits] ? (CoordBits+1)'(0) - ddy : ddy;
					state_q <= S_MUL;
				end
				S_MUL: begin
					d_q <= dsum;
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (req_q.kind == KIND_PATH) begin
						state_q <= S_SQRT;
					end else begin
						if (d_q > best_q) begin
							best_q <= d_q;
							b1_q <= i_q[Ab-1:0];
							b2_q <= j_q[Ab-1:0];
						end
						if (j_q + 1'b1 < cnt_q) begin
							j_q <= j_q + 1'b1;
							state_q <= S_NEXT;
						end else if (i_q + Cb'(2) < cnt_q) begin
							i_q <= i_q + 1'b1;
							j_q <= i_q + Cb'(2);
							state_q <= S_NEXT;
						end else begin
							state_q <= S_DONE;
							rsp.far_dist_sq <= DistBits'(d_q > best_q ? d_q : best_q);
							if (d_q > best_q) begin
								rsp.far_first <= 3'(i_q);
								rsp.far_second <= 3'(j_q);
							end else begin
								rsp.far_first <= 3'(b1_q);
								rsp.far_second <= 3'(b2_q);
							end
						end
					end
				end
				S_SQRT: begin
					if (!sq_busy && !sq_start_q) begin
						if (sum_q + (LenBits+1)'(root) > (LenBits+1)'(LenMax)) begin
							sum_q <= (LenBits+1)'(LenMax);
						end else begin
							sum_q <= sum_q + (LenBits+1)'(root);
						end
						if (j_q + 1'b1 < cnt_q) begin
							i_q <= i_q + 1'b1;
							j_q <= j_q + 1'b1;
							state_q <= S_NEXT;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_NEXT: state_q <= S_RDA;
				S_GETA: begin
					if (first_q || rx < mnx_q) mnx_q <= rx;
					if (first_q || rx > mxx_q) mxx_q <= rx;
					if (first_q || ry < mny_q) mny_q <= ry;
					if (first_q || ry > mxy_q) mxy_q <= ry;
					first_q <= 1'b0;
					if (i_q + 1'b1 < cnt_q) begin
						i_q <= i_q + 1'b1;
						state_q <= S_NEXT;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_MOVE: begin
					j_q <= i_q;
					if (req_q.kind == KIND_DELETE) begin
						state_q <= S_RDA;
					end else begin
						state_q <= S_RDA;
					end
				end
				S_WRNEW: begin
					cnt_q <= cnt_q + 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					rsp_valid <= 1'b1;
					rsp.point_count <= 4'(cnt_q);
					if (req_q.kind == KIND_PATH) begin
						rsp.path_length <= sum_q[LenBits-1:0];
					end
					if (req_q.kind == KIND_BOX && cnt_q != '0) begin
						rsp.box_min_x <= 16'(mnx_q);
						rsp.box_min_y <= 16'(mny_q);
						rsp.box_max_x <= 16'(mxx_q);
						rsp.box_max_y <= 16'(mxy_q);
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: design/plg_ram.sv
// ----------------------------------------------------------------------------
// plg_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module plg_ram #(
	parameter int Width = 32,
	parameter int Depth = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: design/plg_sqrt.sv
// ----------------------------------------------------------------------------
// plg_sqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module plg_sqrt
	import plg_pkg::*;
#(
	parameter int InBits = 50
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [InBits-1:0]   radicand,
	output logic                busy,
	output logic [InBits/2:0]   root
);
	localparam int Half = InBits / 2 + 1;
	localparam int Rb = 2 * Half;
	localparam int CntBits = $clog2(Half + 1);

	logic [Rb-1:0]      rem_q;
	logic [Rb-1:0]      val_q;
	logic [Half-1:0]    res_q;
	logic [CntBits-1:0] cnt_q;
	logic [Rb-1:0]      rem_n;
	logic [Rb-1:0]      trial;

	always_comb begin
		rem_n = {rem_q[Rb-3:0], val_q[Rb-1 -: 2]};
		trial = {{(Rb-Half-2){1'b0}}, res_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy <= 1'b1;
			cnt_q <= CntBits'(Half);
			rem_q <= '0;
			res_q <= '0;
			val_q <= Rb'(radicand);
		end else if (busy) begin
			val_q <= {val_q[Rb-3:0], 2'b00};
			if (rem_n >= trial) begin
				rem_q <= rem_n - trial;
				res_q <= {res_q[Half-2:0], 1'b1};
			end else begin
				rem_q <= rem_n;
				res_q <= {res_q[Half-2:0], 1'b0};
			end
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CntBits'(1)) begin
				busy <= 1'b0;
			end
		end
	end

	assign root = res_q;
endmodule

// File: design/plg_checker.sv
// ----------------------------------------------------------------------------
// plg_checker
// Port-level checks of the point list geometry engine.
// ----------------------------------------------------------------------------
module plg_checker
	import plg_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_ready,
	input plg_req_t req,
	input logic     rsp_valid,
	input logic     rsp_ready,
	input plg_rsp_t rsp
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response dropped while stalled");

	a_no_accept_pending: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("request taken while response pending");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.point_count <= 4'(MaxPointsDef))
		else $error("point count out of range");

	a_one_cycle_min: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !rsp_valid)
		else $error("response too early");
endmodule

bind point_list_geometry_engine_core plg_checker u_plg_checker (.*);

// File: test/tb_point_list_geometry_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_list_geometry_engine_core
// Self-checking bench for the point list engine. A short table of requests
// covers the empty list, the full list, bad indexes and extreme coordinates.
// Random edit and query requests follow. Each response is compared with a
// behavioral model or its table row's expectation; both sides stall at random.
// ----------------------------------------------------------------------------
module tb_point_list_geometry_engine_core;
	import plg_pkg::*;

	localparam int NumRandom = 880;
	localparam int IdleLimit = 20000;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	plg_req_t req = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	plg_rsp_t rsp;

	point_list_geometry_engine_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	always #1 clk = ~clk;

	logic signed [15:0] list_x [MaxPointsDef];
	logic signed [15:0] list_y [MaxPointsDef];
	int unsigned        list_len = 0;

	plg_rsp_t pending_rsp [$];
	bit       typed_valid = 1'b0;
	plg_rsp_t typed_rsp;
	bit       req_taken = 1'b0;
	bit       no_idle = 1'b0;
	int       mismatches = 0;
	int       idle_cycles = 0;

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned res, bits;
		res = 0;
		bits = 64'd1 << 62;
		while (bits > v)
			bits >>= 2;
		while (bits != 0) begin
			if (v >= res + bits) begin
				v -= res + bits;
				res = (res >> 1) + bits;
			end else begin
				res >>= 1;
			end
			bits >>= 2;
		end
		return res;
	endfunction

	function automatic longint unsigned span_sq(int a, int b);
		longint dx, dy;
		dx = longint'(list_x[a]) - longint'(list_x[b]);
		dy = longint'(list_y[a]) - longint'(list_y[b]);
		return longint'(dx * dx + dy * dy);
	endfunction

	function automatic plg_rsp_t apply_request(plg_req_t r);
		plg_rsp_t        o;
		longint unsigned sum, best, d;
		int              pos;
		o = '0;
		pos = int'(r.position);
		case (r.kind)
			KIND_APPEND, KIND_INSERT: begin
				if (list_len >= MaxPointsDef) begin
					o.status = ST_FULL;
				end else if (r.kind == KIND_INSERT && pos > list_len) begin
					o.status = ST_BADIDX;
				end else begin
					if (r.kind == KIND_APPEND)
						pos = list_len;
					for (int k = list_len; k > pos; k--) begin
						list_x[k] = list_x[k - 1];
						list_y[k] = list_y[k - 1];
					end
					list_x[pos] = r.coord_x;
					list_y[pos] = r.coord_y;
					list_len++;
				end
			end
			KIND_DELETE: begin
				if (pos >= list_len) begin
					o.status = ST_BADIDX;
				end else begin
					for (int k = pos; k + 1 < list_len; k++) begin
						list_x[k] = list_x[k + 1];
						list_y[k] = list_y[k + 1];
					end
					list_len--;
				end
			end
			KIND_PATH: begin
				sum = 0;
				for (int k = 0; k + 1 < list_len; k++) begin
					sum += root_floor(span_sq(k, k + 1) << 16);
					if (sum > 64'h0FFF_FFFF)
						sum = 64'h0FFF_FFFF;
				end
				o.path_length = sum[27:0];
			end
			KIND_FAR: begin
				if (list_len < 2) begin
					o.status = ST_FEW;
				end else begin
					o.far_first = 3'd0;
					o.far_second = 3'd1;
					best = span_sq(0, 1);
					for (int k = 0; k < list_len; k++)
						for (int j = k + 1; j < list_len; j++) begin
							d = span_sq(k, j);
							if (d > best) begin
								best = d;
								o.far_first = 3'(k);
								o.far_second = 3'(j);
							end
						end
					o.far_dist_sq = best[32:0];
				end
			end
			KIND_BOX: begin
				if (list_len == 0) begin
					o.status = ST_FEW;
				end else begin
					o.box_min_x = list_x[0];
					o.box_max_x = list_x[0];
					o.box_min_y = list_y[0];
					o.box_max_y = list_y[0];
					for (int k = 1; k < list_len; k++) begin
						if (list_x[k] < o.box_min_x) o.box_min_x = list_x[k];
						if (list_x[k] > o.box_max_x) o.box_max_x = list_x[k];
						if (list_y[k] < o.box_min_y) o.box_min_y = list_y[k];
						if (list_y[k] > o.box_max_y) o.box_max_y = list_y[k];
					end
				end
			end
			default: ;
		endcase
		o.point_count = 4'(list_len);
		return o;
	endfunction

	function automatic int gap_len();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk) begin
		plg_rsp_t p, e;
		if (req_valid && req_ready) begin
			p = apply_request(req);
			pending_rsp.push_back(typed_valid ? typed_rsp : p);
			req_taken = 1'b1;
		end
		if (rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response %p", rsp);
			end else begin
				e = pending_rsp.pop_front();
				if (rsp.status !== e.status || rsp.point_count !== e.point_count ||
						rsp.path_length !== e.path_length ||
						rsp.far_first !== e.far_first || rsp.far_second !== e.far_second ||
						rsp.far_dist_sq !== e.far_dist_sq ||
						rsp.box_min_x !== e.box_min_x || rsp.box_min_y !== e.box_min_y ||
						rsp.box_max_x !== e.box_max_x || rsp.box_max_y !== e.box_max_y) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", e, rsp);
				end
			end
		end
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IdleLimit) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	int ready_hold = 0;
	always @(negedge clk) begin
		if (ready_hold > 0) begin
			rsp_ready = 1'b0;
			ready_hold--;
		end else begin
			rsp_ready = 1'b1;
			ready_hold = gap_len();
		end
	end

	task automatic send_req(plg_req_t r, bit typed, plg_rsp_t e);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		typed_valid = typed;
		typed_rsp = e;
		req = r;
		req_valid = 1'b1;
		do @(negedge clk); while (!req_taken);
		req_taken = 1'b0;
	endtask

	function automatic plg_req_t mk(kind_t k, int pos, int x, int y);
		plg_req_t r;
		r.kind = k;
		r.position = 4'(pos);
		r.coord_x = 16'(x);
		r.coord_y = 16'(y);
		return r;
	endfunction

	function automatic plg_rsp_t st_only(status_t s, int cnt);
		plg_rsp_t o;
		o = '0;
		o.status = s;
		o.point_count = 4'(cnt);
		return o;
	endfunction

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			4: return 16'($urandom_range(0, 31)) - 16'd16;
			default: return 16'($urandom);
		endcase
	endfunction

	typedef struct {
		plg_req_t r;
		bit       typed;
		plg_rsp_t e;
	} stim_row_t;

	stim_row_t stim_rows [$];

	initial begin
		plg_rsp_t  e;
		plg_req_t  r;
		int        w, cnt;
		stim_rows.push_back('{mk(KIND_PATH, 0, 0, 0), 1, st_only(ST_OK, 0)});
		stim_rows.push_back('{mk(KIND_FAR, 0, 0, 0), 1, st_only(ST_FEW, 0)});
		stim_rows.push_back('{mk(KIND_BOX, 0, 0, 0), 1, st_only(ST_FEW, 0)});
		stim_rows.push_back('{mk(KIND_DELETE, 0, 0, 0), 1, st_only(ST_BADIDX, 0)});
		stim_rows.push_back('{mk(KIND_INSERT, 1, 5, 5), 1, st_only(ST_BADIDX, 0)});
		stim_rows.push_back('{mk(KIND_APPEND, 0, -32768, -32768), 1, st_only(ST_OK, 1)});
		stim_rows.push_back('{mk(KIND_FAR, 0, 0, 0), 1, st_only(ST_FEW, 1)});
		stim_rows.push_back('{mk(KIND_PATH, 0, 0, 0), 1, st_only(ST_OK, 1)});
		e = st_only(ST_OK, 1);
		e.box_min_x = -16'sd32768;
		e.box_min_y = -16'sd32768;
		e.box_max_x = -16'sd32768;
		e.box_max_y = -16'sd32768;
		stim_rows.push_back('{mk(KIND_BOX, 0, 0, 0), 1, e});
		stim_rows.push_back('{mk(KIND_APPEND, 0, 32767, 32767), 1, st_only(ST_OK, 2)});
		stim_rows.push_back('{mk(KIND_PATH, 0, 0, 0), 0, e});
		e = st_only(ST_OK, 2);
		e.far_first = 3'd0;
		e.far_second = 3'd1;
		e.far_dist_sq = 33'd8589672450;
		stim_rows.push_back('{mk(KIND_FAR, 0, 0, 0), 1, e});
		stim_rows.push_back('{mk(KIND_INSERT, 0, 0, 0), 0, e});
		stim_rows.push_back('{mk(KIND_INSERT, 3, -32768, 32767), 0, e});
		stim_rows.push_back('{mk(KIND_APPEND, 0, 32767, -32768), 0, e});
		stim_rows.push_back('{mk(KIND_APPEND, 0, 0, 0), 0, e});
		stim_rows.push_back('{mk(KIND_INSERT, 2, 100, -100), 0, e});
		stim_rows.push_back('{mk(KIND_APPEND, 0, -5, 5), 1, st_only(ST_OK, 8)});
		stim_rows.push_back('{mk(KIND_APPEND, 0, 1, 1), 1, st_only(ST_FULL, 8)});
		stim_rows.push_back('{mk(KIND_INSERT, 2, 1, 1), 1, st_only(ST_FULL, 8)});
		stim_rows.push_back('{mk(KIND_PATH, 0, 0, 0), 0, e});
		stim_rows.push_back('{mk(KIND_FAR, 0, 0, 0), 0, e});
		stim_rows.push_back('{mk(KIND_BOX, 0, 0, 0), 0, e});
		stim_rows.push_back('{mk(KIND_DELETE, 15, 0, 0), 1, st_only(ST_BADIDX, 8)});
		r = mk(KIND_APPEND, 15, 0, 0);
		r.kind = 3'd6;
		stim_rows.push_back('{r, 1, st_only(ST_OK, 8)});
		r.kind = 3'd7;
		stim_rows.push_back('{r, 1, st_only(ST_OK, 8)});
		stim_rows.push_back('{mk(KIND_DELETE, 7, 0, 0), 1, st_only(ST_OK, 7)});
		stim_rows.push_back('{mk(KIND_DELETE, 0, 0, 0), 1, st_only(ST_OK, 6)});

		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (stim_rows[i])
			send_req(stim_rows[i].r, stim_rows[i].typed, stim_rows[i].e);

		for (int n = 0; n < NumRandom; n++) begin
			no_idle = (n >= 600 && n < 700);
			if (n == 450) begin
				req_valid = 1'b0;
				while (pending_rsp.size() != 0)
					@(negedge clk);
			end
			cnt = list_len;
			r.coord_x = rand_coord();
			r.coord_y = rand_coord();
			r.position = 4'($urandom_range(0, 15));
			w = $urandom_range(0, 99);
			if (w < 27) begin
				r.kind = KIND_APPEND;
			end else if (w < 47) begin
				r.kind = KIND_INSERT;
				if ($urandom_range(0, 9) != 0)
					r.position = 4'($urandom_range(0, cnt));
			end else if (w < 67) begin
				r.kind = KIND_DELETE;
				if (cnt > 0 && $urandom_range(0, 9) != 0)
					r.position = 4'($urandom_range(0, cnt - 1));
			end else if (w < 77) begin
				r.kind = KIND_PATH;
			end else if (w < 87) begin
				r.kind = KIND_FAR;
			end else if (w < 96) begin
				r.kind = KIND_BOX;
			end else begin
				r.kind = 3'($urandom_range(6, 7));
			end
			send_req(r, 1'b0, '0);
		end
		req_valid = 1'b0;

		while (pending_rsp.size() != 0)
			@(negedge clk);
		repeat (50) @(negedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
